### src/mffe_pkg.sv
`default_nettype none
package mffe_pkg;

    localparam int MAX_FIELDS = 18;
    localparam int LAYOUT_CAP = 17;

    localparam logic [4:0] END_MARK = 5'd31;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;
    localparam logic [1:0] ST_LONG    = 2'd3;

    localparam logic [1:0] PH_LEN_HI = 2'd0;
    localparam logic [1:0] PH_LEN_LO = 2'd1;
    localparam logic [1:0] PH_KIND   = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    // layout lookup for one (kind, cursor)
    typedef struct packed {
        logic       known;
        logic       active;      // cursor inside the kept layout
        logic [3:0] size;        // size of field at cursor
        logic [7:0] end_off;     // exclusive end offset of field at cursor
        logic [7:0] total;       // total layout length
    } t_layout;

    function automatic logic [3:0] f_size(input logic [7:0] k, input int i);
        logic [3:0] s;
        s = 4'd0;
        case (k)
            8'h53: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd1; default: s=4'd0; endcase
            8'h52: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd8; 4,5: s=4'd1; 6: s=4'd4;
                7,8: s=4'd1; 9: s=4'd2; 10,11,12,13,14: s=4'd1; 15: s=4'd4;
                16: s=4'd1; default: s=4'd0; endcase
            8'h48: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd8; 4,5: s=4'd1; 6: s=4'd4;
                default: s=4'd0; endcase
            8'h59: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd8; 4: s=4'd1;
                default: s=4'd0; endcase
            8'h41: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd8; 4: s=4'd1; 5: s=4'd4;
                6: s=4'd8; 7: s=4'd4; default: s=4'd0; endcase
            8'h46: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd8; 4: s=4'd1; 5: s=4'd4;
                6: s=4'd8; 7,8: s=4'd4; default: s=4'd0; endcase
            8'h45: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd8; 4: s=4'd4; 5: s=4'd8;
                default: s=4'd0; endcase
            8'h4C: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd4; 4: s=4'd8; 5,6,7: s=4'd1;
                default: s=4'd0; endcase
            8'h44: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd8; default: s=4'd0; endcase
            8'h58: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd8; 4: s=4'd4;
                default: s=4'd0; endcase
            8'h55: case (i) 0,1: s=4'd2; 2: s=4'd6; 3,4: s=4'd8; 5,6: s=4'd4;
                default: s=4'd0; endcase
            8'h50: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd8; 4: s=4'd1; 5: s=4'd4;
                6: s=4'd8; 7: s=4'd4; 8: s=4'd8; default: s=4'd0; endcase
            8'h43: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd8; 4: s=4'd4; 5: s=4'd8;
                6: s=4'd1; 7: s=4'd4; default: s=4'd0; endcase
            8'h51: case (i) 0,1: s=4'd2; 2: s=4'd6; 3,4: s=4'd8; 5: s=4'd4; 6: s=4'd8;
                7: s=4'd1; default: s=4'd0; endcase
            8'h49: case (i) 0,1: s=4'd2; 2: s=4'd6; 3,4: s=4'd8; 5: s=4'd1; 6: s=4'd8;
                7,8,9: s=4'd4; 10,11: s=4'd1; default: s=4'd0; endcase
            8'h56: case (i) 0,1: s=4'd2; 2: s=4'd6; 3,4,5: s=4'd8; default: s=4'd0; endcase
            8'h4B: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd8; 4: s=4'd4; 5: s=4'd1;
                6: s=4'd4; default: s=4'd0; endcase
            8'h4A: case (i) 0,1: s=4'd2; 2: s=4'd6; 3: s=4'd8; 4,5,6,7: s=4'd4;
                default: s=4'd0; endcase
            default: s = 4'd0;
        endcase
        // fields past MAX_FIELDS are not used
        if (i >= MAX_FIELDS) s = 4'd0;
        return s;
    endfunction

    function automatic t_layout f_layout(input logic [7:0] k, input logic [4:0] cur);
        t_layout    l;
        logic [7:0] acc;
        logic [3:0] s;
        l   = '0;
        acc = 8'd0;
        l.known = (f_size(k, 0) != 4'd0);
        for (int i = 0; i < LAYOUT_CAP; i++) begin
            s   = f_size(k, i);
            acc = acc + {4'd0, s};
            if (5'(i) == cur) begin
                l.size    = s;
                l.end_off = acc;
                l.active  = (s != 4'd0);
            end
        end
        l.total = acc;
        return l;
    endfunction

    typedef struct packed {
        logic [7:0]  kind;
        logic [4:0]  index;
        logic [63:0] value;
        logic [3:0]  size;
        logic        last;
        logic [1:0]  status;
    } t_result;

endpackage
`default_nettype wire

### src/mffe_parser.sv
`default_nettype none
module mffe_parser
    import mffe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    output t_result         o_res,
    output logic            o_res_vld
);
    logic [1:0]  r_phase;
    logic [15:0] r_len_left;
    logic [7:0]  r_len_high;
    logic [15:0] r_body_off;
    logic [7:0]  r_kind;
    logic [4:0]  r_cursor;
    logic [63:0] r_accum;

    logic [1:0]  n_phase;
    logic [15:0] n_len_left;
    logic [7:0]  n_len_high;
    logic [15:0] n_body_off;
    logic [7:0]  n_kind;
    logic [4:0]  n_cursor;
    logic [63:0] n_accum;

    t_layout     lay;
    logic [63:0] shifted;
    logic [15:0] len_dec;
    logic [15:0] off_inc;

    assign lay     = f_layout(r_kind, r_cursor);
    assign shifted = {r_accum[55:0], i_byte};
    assign len_dec = r_len_left - 16'd1;
    assign off_inc = r_body_off + 16'd1;

    // per-byte framing and field assembly
    always_comb begin
        n_phase    = r_phase;
        n_len_left = r_len_left;
        n_len_high = r_len_high;
        n_body_off = r_body_off;
        n_kind     = r_kind;
        n_cursor   = r_cursor;
        n_accum    = r_accum;
        o_res      = '0;
        o_res_vld  = 1'b0;
        unique case (r_phase)
            PH_LEN_HI: begin
                n_len_high = i_byte;
                n_phase    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if ({r_len_high, i_byte} == 16'd0) begin
                    n_phase     = PH_LEN_HI;
                    o_res_vld   = 1'b1;
                    o_res.index = END_MARK;
                    o_res.last  = 1'b1;
                end else begin
                    n_len_left = {r_len_high, i_byte};
                    n_phase    = PH_KIND;
                end
            end
            PH_KIND: begin
                n_kind     = i_byte;
                n_len_left = len_dec;
                n_body_off = 16'd0;
                n_cursor   = 5'd0;
                n_accum    = 64'd0;
                if (len_dec == 16'd0) begin
                    n_phase      = PH_LEN_HI;
                    o_res_vld    = 1'b1;
                    o_res.kind   = i_byte;
                    o_res.index  = END_MARK;
                    o_res.last   = 1'b1;
                    o_res.status = (f_size(i_byte, 0) == 4'd0) ? ST_UNKNOWN : ST_SHORT;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_len_left  = len_dec;
                n_body_off  = off_inc;
                o_res.kind  = r_kind;
                o_res.index = END_MARK;
                if (lay.active) begin
                    n_accum = shifted;
                    if (off_inc == {8'd0, lay.end_off}) begin
                        o_res_vld   = 1'b1;
                        o_res.index = r_cursor;
                        o_res.value = shifted;
                        o_res.size  = lay.size;
                        n_accum     = 64'd0;
                        n_cursor    = r_cursor + 5'd1;
                    end
                end
                if (len_dec == 16'd0) begin
                    n_phase    = PH_LEN_HI;
                    o_res_vld  = 1'b1;
                    o_res.last = 1'b1;
                    if (!lay.known)                       o_res.status = ST_UNKNOWN;
                    else if (off_inc < {8'd0, lay.total}) o_res.status = ST_SHORT;
                    else if (off_inc > {8'd0, lay.total}) o_res.status = ST_LONG;
                    else                                  o_res.status = ST_OK;
                end
            end
            default: n_phase = PH_LEN_HI;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEN_HI;
            r_len_left <= '0;
            r_len_high <= '0;
            r_body_off <= '0;
            r_kind     <= '0;
            r_cursor   <= '0;
            r_accum    <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_len_left <= n_len_left;
            r_len_high <= n_len_high;
            r_body_off <= n_body_off;
            r_kind     <= n_kind;
            r_cursor   <= n_cursor;
            r_accum    <= n_accum;
        end
    end
endmodule
`default_nettype wire

### src/mffe_out_reg.sv
`default_nettype none
module mffe_out_reg
    import mffe_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_res
);
    logic r_valid;
    t_result r_res;

    // result register: loads on a new result, clears on output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule
`default_nettype wire

### src/market_feed_field_extractor.sv
`default_nettype none
// Feed field extractor: one byte per cycle, unless a held result is not taken.
// A result is registered and appears on the output in the cycle after the byte that causes it.
// Throughput: one byte per cycle while the output is taken; input stalls only
// when a result is held and not taken.
// Reset: synchronous active-low i_rst_n; parser returns to waiting for a length.
module market_feed_field_extractor
    import mffe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_msg_kind,
    output logic [4:0]       o_field_index,
    output logic [63:0]      o_field_value,
    output logic [3:0]       o_field_size,
    output logic             o_is_last,
    output logic [1:0]       o_status
);
    logic    fire;
    logic    res_vld;
    t_result res;
    t_result out_res;

    // accept whenever the result register is free or being drained
    assign o_ready = !o_valid || i_ready;
    assign fire    = i_valid && o_ready;

    mffe_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (i_data_byte),
        .o_res     (res),
        .o_res_vld (res_vld)
    );

    mffe_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && res_vld),
        .i_res   (res),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_msg_kind    = out_res.kind;
    assign o_field_index = out_res.index;
    assign o_field_value = out_res.value;
    assign o_field_size  = out_res.size;
    assign o_is_last     = out_res.last;
    assign o_status      = out_res.status;
endmodule
`default_nettype wire

### tb/sv/mffe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mffe_checker
    import mffe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        o_valid,
    input  wire logic        i_ready,
    input  wire logic [7:0]  o_msg_kind,
    input  wire logic [4:0]  o_field_index,
    input  wire logic [63:0] o_field_value,
    input  wire logic [3:0]  o_field_size,
    input  wire logic        o_is_last,
    input  wire logic [1:0]  o_status,
    output int               fail_count,
    output int               pending_fields,
    output int               field_count
);

    // parser state mirror
    logic [1:0]  frame_phase;
    logic [15:0] bytes_left;
    logic [7:0]  len_hi;
    logic [15:0] offset;
    logic [7:0]  kind;
    logic [4:0]  cursor;
    logic [63:0] accum;

    t_result field_q[$];

    // field sizes per message type, by ASCII code
    function automatic int sizes_of(input logic [7:0] k, input int i);
        int t[$];
        case (k)
            "S": t = '{2, 2, 6, 1};
            "R": t = '{2, 2, 6, 8, 1, 1, 4, 1, 1, 2, 1, 1, 1, 1, 1, 4, 1};
            "H": t = '{2, 2, 6, 8, 1, 1, 4};
            "Y": t = '{2, 2, 6, 8, 1};
            "A": t = '{2, 2, 6, 8, 1, 4, 8, 4};
            "F": t = '{2, 2, 6, 8, 1, 4, 8, 4, 4};
            "E": t = '{2, 2, 6, 8, 4, 8};
            "L": t = '{2, 2, 6, 4, 8, 1, 1, 1};
            "D": t = '{2, 2, 6, 8};
            "X": t = '{2, 2, 6, 8, 4};
            "U": t = '{2, 2, 6, 8, 8, 4, 4};
            "P": t = '{2, 2, 6, 8, 1, 4, 8, 4, 8};
            "C": t = '{2, 2, 6, 8, 4, 8, 1, 4};
            "Q": t = '{2, 2, 6, 8, 8, 4, 8, 1};
            "I": t = '{2, 2, 6, 8, 8, 1, 8, 4, 4, 4, 1, 1};
            "V": t = '{2, 2, 6, 8, 8, 8};
            "K": t = '{2, 2, 6, 8, 4, 1, 4};
            "J": t = '{2, 2, 6, 8, 4, 4, 4, 4};
            default: t = {};
        endcase
        if (i < t.size() && i < MAX_FIELDS) return t[i];
        return 0;
    endfunction

    function automatic int end_of(input logic [7:0] k, input int n);
        int e;
        e = 0;
        for (int i = 0; i <= n; i++) e += sizes_of(k, i);
        return e;
    endfunction

    // advance the mirror by one byte, queue any field it yields
    task automatic parse_byte(input logic [7:0] b);
        t_result r;
        logic    fin, got, known;
        int      need;
        r = '0;
        got = 0;
        case (frame_phase)
            PH_LEN_HI: begin
                len_hi = b;
                frame_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if ({len_hi, b} == 16'd0) begin
                    frame_phase = PH_LEN_HI;
                    r.index = END_MARK;
                    r.last = 1;
                    r.status = ST_OK;
                    field_q.push_back(r);
                end else begin
                    bytes_left = {len_hi, b};
                    frame_phase = PH_KIND;
                end
            end
            PH_KIND: begin
                kind = b;
                bytes_left--;
                offset = 0;
                cursor = 0;
                accum = 0;
                if (bytes_left == 0) begin
                    frame_phase = PH_LEN_HI;
                    r.kind = kind;
                    r.index = END_MARK;
                    r.last = 1;
                    r.status = (sizes_of(kind, 0) == 0) ? ST_UNKNOWN : ST_SHORT;
                    field_q.push_back(r);
                end else begin
                    frame_phase = PH_BODY;
                end
            end
            default: begin
                bytes_left--;
                fin = (bytes_left == 0);
                known = (sizes_of(kind, 0) != 0);
                r.kind = kind;
                if (known && sizes_of(kind, cursor) != 0) begin
                    accum = (accum << 8) | b;
                    if (offset + 1 == end_of(kind, cursor)) begin
                        r.index = cursor;
                        r.size = sizes_of(kind, cursor);
                        r.value = accum;
                        accum = 0;
                        cursor++;
                        got = 1;
                    end
                end
                offset++;
                if (fin) begin
                    frame_phase = PH_LEN_HI;
                    need = end_of(kind, 31);
                    if (!known) r.status = ST_UNKNOWN;
                    else if (offset < need) r.status = ST_SHORT;
                    else if (offset > need) r.status = ST_LONG;
                    else r.status = ST_OK;
                    r.last = 1;
                    if (!got) r.index = END_MARK;
                end
                if (got || fin) field_q.push_back(r);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result a, e;
        if (!i_rst_n) begin
            frame_phase = PH_LEN_HI;
            bytes_left = 0;
            len_hi = 0;
            offset = 0;
            kind = 0;
            cursor = 0;
            accum = 0;
            field_q.delete();
            fail_count <= 0;
            field_count <= 0;
        end else begin
            // result side first: a result never comes from the same-edge byte
            if (o_valid && i_ready) begin
                field_count <= field_count + 1;
                a = '{o_msg_kind, o_field_index, o_field_value, o_field_size,
                      o_is_last, o_status};
                if (field_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, a);
                    fail_count <= fail_count + 1;
                end else begin
                    e = field_q.pop_front();
                    if (a !== e) begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, e, a);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (i_valid && o_ready) parse_byte(i_data_byte);
        end
        pending_fields <= field_q.size();
    end

    initial frame_phase = PH_LEN_HI;

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import mffe_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic [7:0]  in_byte = 0;
    logic        out_ready = 0;
    logic        in_ready, out_valid, is_last;
    logic [7:0]  msg_kind;
    logic [4:0]  field_index;
    logic [63:0] field_value;
    logic [3:0]  field_size;
    logic [1:0]  status;
    int          fail_count, pending_fields, field_count;
    int          bytes_sent = 0;
    int          msgs_sent = 0;
    bit          calm = 0;     // no idling in the final stretch
    bit          hold_out = 0; // long receiver hold-off

    localparam logic [7:0] KINDS[18] = '{"S", "R", "H", "Y", "A", "F", "E", "L", "D",
                                         "X", "U", "P", "C", "Q", "I", "V", "K", "J"};
    localparam int LAYOUT_LEN[18] = '{11, 38, 24, 19, 35, 39, 30, 25, 18, 22, 34, 43,
                                      35, 39, 49, 34, 27, 34};

    always #1 clk = ~clk;

    market_feed_field_extractor dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_data_byte(in_byte), .o_valid(out_valid), .i_ready(out_ready),
        .o_msg_kind(msg_kind), .o_field_index(field_index), .o_field_value(field_value),
        .o_field_size(field_size), .o_is_last(is_last), .o_status(status)
    );

    mffe_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_data_byte(in_byte), .o_valid(out_valid), .i_ready(out_ready),
        .o_msg_kind(msg_kind), .o_field_index(field_index), .o_field_value(field_value),
        .o_field_size(field_size), .o_is_last(is_last), .o_status(status),
        .fail_count(fail_count), .pending_fields(pending_fields),
        .field_count(field_count)
    );

    // one byte transfer, with random idle bursts before it
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1;
        in_byte <= b;
        @(posedge clk iff in_ready);
        bytes_sent++;
    endtask

    // framed message: length covers type byte and body
    task automatic send_msg(input logic [7:0] k, input int body_len, input bit ones);
        logic [15:0] n;
        n = 16'(body_len + 1);
        send_byte(n[15:8]);
        send_byte(n[7:0]);
        send_byte(k);
        for (int i = 0; i < body_len; i++)
            send_byte(ones ? 8'hFF : 8'($urandom));
        msgs_sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending_fields != 0 || (out_valid && !out_ready)) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver: random stall bursts, or a long hold-off on request
    initial begin
        @(posedge clk);
        forever begin
            if (hold_out) begin
                out_ready <= 0;
                repeat (60) @(posedge clk);
                hold_out = 0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                out_ready <= 0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end else begin
                out_ready <= 1;
                @(posedge clk);
            end
        end
    end

    initial begin
        int s, len;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty message, bare type byte, unknown type, short and long, exact layouts
        send_byte(8'h00);
        send_byte(8'h00);
        send_msg("S", 0, 0);
        send_msg(8'h00, 3, 0);
        send_msg("S", 11, 1);
        send_msg("S", 5, 0);
        send_msg("S", 14, 0);
        for (int i = 0; i < 18; i++) send_msg(KINDS[i], LAYOUT_LEN[i], i[0]);
        drain();

        // long receiver hold-off while bytes keep coming
        hold_out = 1;
        send_msg("I", 50, 0);
        send_msg("R", 39, 0);
        drain();

        // random messages: mostly well-formed, some short/long/unknown/empty
        while (bytes_sent < 1300) begin
            s = $urandom_range(0, 17);
            len = LAYOUT_LEN[s];
            case ($urandom_range(0, 9))
                0: len = $urandom_range(0, len - 1);
                1: len = len + $urandom_range(1, 6);
                2: begin
                    send_msg(8'($urandom), $urandom_range(0, 12), 0);
                    continue;
                end
                3: begin
                    send_byte(8'h00);
                    send_byte(8'h00);
                    continue;
                end
                default: ;
            endcase
            if (bytes_sent > 1100) calm = 1;
            send_msg(KINDS[s], len, $urandom_range(0, 15) == 0);
        end
        // long message with a nonzero length high byte, last
        send_msg("D", 300, 0);
        drain();

        $display("Parsed %0d messages (%0d bytes), %0d results checked.",
                 msgs_sent, bytes_sent, field_count);
        $display("Covered all types, empty, short, long and unknown messages.");
        if (fail_count == 0) begin
            $display("[market_feed_field_extractor] OK");
        end else begin
            $display("[market_feed_field_extractor] ERROR");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("[market_feed_field_extractor] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
